// ===== src/rpe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpe_pkg: shared types and constants of the ray profile edge detector
// Payload structs, register indexes, the derivative-of-Gaussian coefficient
// table and the control groups that pass between the top level and its parts.
// ----------------------------------------------------------------------------
package rpe_pkg;

  localparam int SAMPLE_BITS       = 16;
  localparam int TAP_RADIUS_DEF    = 15;
  localparam int MAX_SAMPLES_DEF   = 256;
  localparam int COEF_W            = 16;
  localparam int COEF_RADIUS       = 15;
  localparam int STAGE_ONE_SHIFT   = 12;
  localparam int Y1_W              = SAMPLE_BITS + 16;
  localparam int ACC_W             = Y1_W + COEF_W;
  localparam int THRESH_W          = 16;
  localparam int START_W           = 8;
  localparam int INDEX_W           = 8;
  localparam int CFG_DATA_W        = 16;
  localparam int CFG_INDEX_W       = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_BRIGHT_THRESHOLD = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SEARCH_START     = 1'd1;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd4000;
  localparam logic [START_W-1:0]  START_RESET  = 8'd90;

  localparam logic [COEF_W-1:0] DOG_MAG [COEF_RADIUS+1] = '{
    16'd0,     16'd6561,  16'd12357, 16'd16772, 16'd19441, 16'd20298,
    16'd19547, 16'd17584, 16'd14888, 16'd11921, 16'd9058,  16'd6547,
    16'd4509,  16'd2962,  16'd1859,  16'd1115
  };

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last;
  } in_req_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] edge_index;
  } out_rsp_t;

  // control of one tap row: synchronous clear and take-from-neighbor
  typedef struct packed {
    logic clr;
    logic en;
  } cell_ctl_t;

  // control of the multiply-accumulate unit
  typedef struct packed {
    logic clr;
    logic en;
  } mac_ctl_t;

  // coefficient at tap offset off; zero beyond the table
  function automatic logic signed [COEF_W-1:0] dog_coef(input int off);
    int                 a;
    logic [COEF_W-1:0]  mag;
    a = (off < 0) ? -off : off;
    if (a > COEF_RADIUS) begin
      return '0;
    end
    mag = DOG_MAG[a[3:0]];
    return (off > 0) ? -signed'(mag) : signed'(mag);
  endfunction

endpackage
`default_nettype wire

// ===== src/rpe_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpe_cell: one tap of a filter row
// Holds one value, takes its input value when enabled and clears on reset or clear.
// ----------------------------------------------------------------------------
module rpe_cell #(
  parameter int W = rpe_pkg::SAMPLE_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rpe_pkg::cell_ctl_t ctl,
  input  wire logic [W-1:0]      d,
  output logic      [W-1:0]      q
);

  logic [W-1:0] q_r;

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      q_r <= '0;
    end else if (ctl.en) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule
`default_nettype wire

// ===== src/rpe_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpe_mac: shared multiply-accumulate unit
// Registers each product, then adds the registered product into the accumulator.
// ----------------------------------------------------------------------------
module rpe_mac (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire rpe_pkg::mac_ctl_t                 ctl,
  input  wire logic signed [rpe_pkg::Y1_W-1:0]   operand,
  input  wire logic signed [rpe_pkg::COEF_W-1:0] coef,
  output logic signed      [rpe_pkg::ACC_W-1:0]  acc
);

  logic signed [rpe_pkg::ACC_W-1:0] prod_r;
  logic                             pv_r;
  logic signed [rpe_pkg::ACC_W-1:0] acc_r;

  always_ff @(posedge clk) begin
    prod_r <= operand * coef;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      pv_r  <= 1'b0;
      acc_r <= '0;
    end else begin
      pv_r <= ctl.en;
      if (pv_r) begin
        acc_r <= acc_r + prod_r;
      end
    end
  end

  assign acc = acc_r;

endmodule
`default_nettype wire

// ===== src/ray_profile_edge_detector.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ray_profile_edge_detector: edge search along one ray profile
// Double derivative-of-Gaussian filter over two rows of tap cells, zero-crossing
// search on the response, one result per ray on the last sample.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | in_req  (sample, last)
//  out_    | output    | out_valid/out_stall| out_rsp (found, edge_index)
//  cfg_    | input     | cfg_we             | cfg_index, cfg_data
//
// Operation: a request runs both filter stages once the filter is full, only
// stage one or neither early in a ray; the single shared multiply-accumulate
// unit walks each tap row once per filter stage.
// Reset: synchronous on rst_n low; clears the ray state and loads the
// register defaults (threshold 4000, search start 90).
// Stalls: a finished result waits in the output register while new requests
// are taken; a ray end meeting a still-full output register holds in_stall.
// ----------------------------------------------------------------------------
module ray_profile_edge_detector #(
  parameter int TAP_RADIUS      = rpe_pkg::TAP_RADIUS_DEF,
  parameter int MAX_RAY_SAMPLES = rpe_pkg::MAX_SAMPLES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire rpe_pkg::in_req_t                   in_req,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output rpe_pkg::out_rsp_t                       out_rsp,
  input  wire logic                               cfg_we,
  input  wire logic [rpe_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [rpe_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int TAPS  = 2 * TAP_RADIUS + 1;
  localparam int KW    = $clog2(TAPS + 1);
  localparam int CNT_W = $clog2(MAX_RAY_SAMPLES + 1);
  localparam int CMP_W = (CNT_W > rpe_pkg::START_W) ? CNT_W : rpe_pkg::START_W;
  localparam int SB    = rpe_pkg::SAMPLE_BITS;
  localparam int YW    = rpe_pkg::Y1_W;
  localparam int AW    = rpe_pkg::ACC_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_S1     = 3'd1;
  localparam logic [2:0] ST_S1_END = 3'd2;
  localparam logic [2:0] ST_S2     = 3'd3;
  localparam logic [2:0] ST_S2_END = 3'd4;
  localparam logic [2:0] ST_FIN    = 3'd5;

  // registers
  logic [2:0]                       state_r, state_nxt;
  logic [KW-1:0]                    k_r, k_nxt;
  logic [CNT_W-1:0]                 count_r, count_nxt;
  logic [CNT_W-1:0]                 t_r, t_nxt;
  logic                             last_r, last_nxt;
  logic [rpe_pkg::THRESH_W-1:0]     thresh_r;
  logic [rpe_pkg::START_W-1:0]      start_r;
  logic signed [AW-1:0]             prev_r, prev_nxt;
  logic                             armed_r, armed_nxt;
  logic                             found_r, found_nxt;
  logic [rpe_pkg::INDEX_W-1:0]      pos_r, pos_nxt;
  logic                             out_valid_r, out_valid_nxt;
  rpe_pkg::out_rsp_t                out_rsp_r, out_rsp_nxt;

  // tap rows
  logic [SB-1:0]        raw_q [TAPS];
  logic [YW-1:0]        s2_q  [TAPS];
  logic [SB-1:0]        raw_end;
  logic [YW-1:0]        s2_end;
  rpe_pkg::cell_ctl_t   raw_ctl, s2_ctl;

  // MAC
  rpe_pkg::mac_ctl_t          mac_ctl;
  logic signed [YW-1:0]       mac_op;
  logic signed [rpe_pkg::COEF_W-1:0] mac_coef;
  logic signed [AW-1:0]       acc;
  logic signed [AW-1:0]       acc_shr;
  logic [YW-1:0]              y1;

  // detection
  logic                 det_en;
  logic signed [AW-1:0] det_r;
  logic [CNT_W-1:0]     j;
  logic [CMP_W-1:0]     j_ext;
  logic [CMP_W-1:0]     start_ext;
  logic                 arm_now;
  logic                 clr_ray;
  logic                 take;

  genvar gi;
  generate
    for (gi = 0; gi < TAPS; gi++) begin : g_row
      if (gi == TAPS - 1) begin : g_end
        rpe_cell #(.W(SB)) u_raw (
          .clk(clk), .rst_n(rst_n), .ctl(raw_ctl), .d(raw_end), .q(raw_q[gi])
        );
        rpe_cell #(.W(YW)) u_s2 (
          .clk(clk), .rst_n(rst_n), .ctl(s2_ctl), .d(s2_end), .q(s2_q[gi])
        );
      end else begin : g_mid
        rpe_cell #(.W(SB)) u_raw (
          .clk(clk), .rst_n(rst_n), .ctl(raw_ctl), .d(raw_q[gi+1]), .q(raw_q[gi])
        );
        rpe_cell #(.W(YW)) u_s2 (
          .clk(clk), .rst_n(rst_n), .ctl(s2_ctl), .d(s2_q[gi+1]), .q(s2_q[gi])
        );
      end
    end
  endgenerate

  rpe_mac u_mac (
    .clk(clk), .rst_n(rst_n), .ctl(mac_ctl),
    .operand(mac_op), .coef(mac_coef), .acc(acc)
  );

  // stage-one result: floor divide by 2^12
  assign acc_shr  = acc >>> rpe_pkg::STAGE_ONE_SHIFT;
  assign y1       = acc_shr[YW-1:0];
  assign mac_coef = rpe_pkg::dog_coef(int'(k_r) - TAP_RADIUS);
  assign mac_op   = (state_r == ST_S2) ? signed'(s2_q[0])
                                       : signed'({{(YW-SB){1'b0}}, raw_q[0]});

  assign j         = t_r - CNT_W'(2 * TAP_RADIUS);
  assign j_ext     = CMP_W'(j);
  assign start_ext = CMP_W'(start_r);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    count_nxt     = count_r;
    t_nxt         = t_r;
    last_nxt      = last_r;
    raw_ctl       = '0;
    s2_ctl        = '0;
    mac_ctl       = '0;
    raw_end       = raw_q[0];
    s2_end        = s2_q[0];
    det_en        = 1'b0;
    det_r         = '0;
    clr_ray       = 1'b0;
    take          = 1'b0;
    out_valid_nxt = out_valid_r & out_stall;
    out_rsp_nxt   = out_rsp_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          take     = (count_r < CNT_W'(MAX_RAY_SAMPLES));
          t_nxt    = count_r;
          last_nxt = in_req.last;
          if (take) begin
            // shift the new sample into the raw row
            raw_ctl.en = 1'b1;
            raw_end    = in_req.sample;
            count_nxt  = count_r + CNT_W'(1);
            // stage-one outputs ahead of the full window are zero
            if (count_r >= CNT_W'(TAP_RADIUS) && count_r < CNT_W'(2 * TAP_RADIUS)) begin
              s2_ctl.en = 1'b1;
              s2_end    = '0;
            end
          end
          if (take && count_r >= CNT_W'(2 * TAP_RADIUS)) begin
            state_nxt   = ST_S1;
            k_nxt       = '0;
            mac_ctl.clr = 1'b1;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_S1: begin
        // rotate the raw row past the MAC, then drain
        if (k_r < KW'(TAPS)) begin
          raw_ctl.en = 1'b1;
          mac_ctl.en = 1'b1;
          k_nxt      = k_r + KW'(1);
        end else begin
          state_nxt = ST_S1_END;
        end
      end
      ST_S1_END: begin
        s2_ctl.en = 1'b1;
        s2_end    = y1;
        if (j >= CNT_W'(TAP_RADIUS)) begin
          state_nxt   = ST_S2;
          k_nxt       = '0;
          mac_ctl.clr = 1'b1;
        end else begin
          det_en    = 1'b1;
          det_r     = '0;
          state_nxt = ST_FIN;
        end
      end
      ST_S2: begin
        if (k_r < KW'(TAPS)) begin
          s2_ctl.en  = 1'b1;
          mac_ctl.en = 1'b1;
          k_nxt      = k_r + KW'(1);
        end else begin
          state_nxt = ST_S2_END;
        end
      end
      ST_S2_END: begin
        det_en    = 1'b1;
        det_r     = acc;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if (!out_valid_r || !out_stall) begin
          // emit the ray result and drop all ray state
          out_valid_nxt          = 1'b1;
          out_rsp_nxt.found      = found_r;
          out_rsp_nxt.edge_index = found_r ? pos_r : '0;
          clr_ray                = 1'b1;
          raw_ctl.clr            = 1'b1;
          s2_ctl.clr             = 1'b1;
          count_nxt              = '0;
          state_nxt              = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // zero-crossing search
  always_comb begin
    prev_nxt  = prev_r;
    armed_nxt = armed_r;
    found_nxt = found_r;
    pos_nxt   = pos_r;
    arm_now   = armed_r;
    if (clr_ray) begin
      prev_nxt  = '0;
      armed_nxt = 1'b0;
      found_nxt = 1'b0;
      pos_nxt   = '0;
    end else if (det_en) begin
      if (!found_r && j != '0) begin
        arm_now = armed_r | ((j_ext > start_ext) && (prev_r < 0) && (det_r > 0));
        armed_nxt = arm_now;
        if (arm_now && det_r < prev_r) begin
          if (32'(raw_q[0]) > 32'(thresh_r)) begin
            armed_nxt = 1'b0;
          end else begin
            found_nxt = 1'b1;
            pos_nxt   = j_ext[rpe_pkg::INDEX_W-1:0];
          end
        end
      end
      prev_nxt = det_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      count_r     <= '0;
      t_r         <= '0;
      last_r      <= 1'b0;
      prev_r      <= '0;
      armed_r     <= 1'b0;
      found_r     <= 1'b0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      count_r     <= count_nxt;
      t_r         <= t_nxt;
      last_r      <= last_nxt;
      prev_r      <= prev_nxt;
      armed_r     <= armed_nxt;
      found_r     <= found_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_rsp_r <= out_rsp_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= rpe_pkg::THRESH_RESET;
      start_r  <= rpe_pkg::START_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rpe_pkg::REG_BRIGHT_THRESHOLD: thresh_r <= cfg_data[rpe_pkg::THRESH_W-1:0];
        rpe_pkg::REG_SEARCH_START:     start_r  <= cfg_data[rpe_pkg::START_W-1:0];
        default: begin
          thresh_r <= thresh_r;
        end
      endcase
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // checks
  a_emit_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FIN)
    else $error("result appeared outside the finish step");

  a_no_index_without_edge: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_rsp_r.found) |-> out_rsp_r.edge_index == '0)
    else $error("edge index set without an edge");

  a_tap_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= KW'(TAPS))
    else $error("tap walk ran past the row");

  a_ray_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && last_r && (!out_valid_r || !out_stall)) |=>
      (count_r == '0 && !found_r && !armed_r))
    else $error("ray state kept after the result");

endmodule
`default_nettype wire
